FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_AT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_AT(name, clk, rst, prop, msg)
`define ASSERT_NEVER(name, clk, rst, expr, msg)

`endif

`endif

FILE: src/plvp_pkg.sv
// ----------------------------------------------------------------------------
// plvp_pkg
// Types and codes of the posting list variable-byte parser.
// ----------------------------------------------------------------------------
package plvp_pkg;

   // parse phase codes
   localparam logic [2:0] PH_WLEN   = 3'd0;
   localparam logic [2:0] PH_WORD   = 3'd1;
   localparam logic [2:0] PH_NPOSTS = 3'd2;
   localparam logic [2:0] PH_DOC    = 3'd3;
   localparam logic [2:0] PH_EARLY  = 3'd4;
   localparam logic [2:0] PH_NENT   = 3'd5;
   localparam logic [2:0] PH_VARINT = 3'd6;
   localparam logic [2:0] PH_LOC    = 3'd7;

   // result kind codes
   localparam logic [1:0] KIND_WORD_BYTE = 2'd0;
   localparam logic [1:0] KIND_POST_HDR  = 2'd1;
   localparam logic [1:0] KIND_ENTRY     = 2'd2;
   localparam logic [1:0] KIND_LIST_END  = 2'd3;

   // field sizes in bytes, as last byte index
   localparam logic [2:0] LAST_IDX_WLEN = 3'd1;
   localparam logic [2:0] LAST_IDX_DOC  = 3'd3;
   localparam logic [2:0] LAST_IDX_Q64  = 3'd7;

   // variable-byte coding
   localparam logic [7:0] VB_DATA_MASK = 8'h7F;
   localparam logic [7:0] VB_END_BIT   = 8'h80;
   localparam logic [5:0] SHIFT_STEP   = 6'd7;
   localparam logic [5:0] SHIFT_CAP    = 6'd35;
   localparam logic [5:0] SHIFT_LIMIT  = 6'd32;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  word_byte;
      logic [31:0] doc_id;
      logic [63:0] earliest_start;
      logic [31:0] position;
      logic [7:0]  location;
      logic        last_in_post;
      logic        last_in_list;
   } result_type;

endpackage

FILE: src/posting_list_delta_varbyte_parser_top.sv
// ----------------------------------------------------------------------------
// posting_list_delta_varbyte_parser_top
// Byte-serial parser of a delta/variable-byte coded posting list.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   req     | in        | req_valid/req_stall| req_in_byte
//   rsp     | out       | rsp_valid/rsp_stall| kind, word, doc, start, pos...
//
// One stream byte is taken every cycle while req_stall is low; its result,
// if any, is registered in the output register, or in the skid register
// while the output is stalled. Parse state updates in the cycle of the
// transfer.
// A one-entry skid register holds a result while the output is stalled;
// req_stall rises only while that skid register is full.
// Synchronous active-high reset clears the phase, counters and valid flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module posting_list_delta_varbyte_parser_top
   import plvp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_word_byte,
   output logic [31:0] rsp_doc_id,
   output logic [63:0] rsp_earliest_start,
   output logic [31:0] rsp_position,
   output logic [7:0]  rsp_location,
   output logic        rsp_last_in_post,
   output logic        rsp_last_in_list
);

   // parse state
   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] asm_ff, asm_in;
   logic [15:0] word_left_ff, word_left_in;
   logic [63:0] posts_left_ff, posts_left_in;
   logic [63:0] entries_left_ff, entries_left_in;
   logic [31:0] doc_ff, doc_in;
   logic [63:0] early_ff, early_in;
   logic [31:0] vint_ff, vint_in;
   logic [5:0]  shift_ff, shift_in;
   logic [31:0] prev_pos_ff, prev_pos_in;

   // output and skid registers
   logic        rsp_valid_ff;
   logic        skid_valid_ff;
   result_type  rsp_data_ff;
   result_type  skid_data_ff;

   logic        accept;
   logic        rsp_take;
   logic        produce;
   result_type  result;

   logic [63:0] asm_full;
   logic [15:0] word_left_dec;
   logic [63:0] posts_left_dec;
   logic [63:0] entries_left_dec;
   logic [31:0] pos_sum;
   logic [5:0]  shift_add;

   assign accept   = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   // field byte lands at its little-endian place
   assign asm_full = asm_ff | ({56'd0, req_in_byte} << {idx_ff, 3'b000});

   assign word_left_dec    = word_left_ff - 16'd1;
   assign posts_left_dec   = posts_left_ff - 64'd1;
   assign entries_left_dec = entries_left_ff - 64'd1;
   assign pos_sum          = prev_pos_ff + vint_ff;
   assign shift_add        = shift_ff + SHIFT_STEP;

   // next state and result for one stream byte
   always_comb begin
      phase_in        = phase_ff;
      idx_in          = idx_ff;
      asm_in          = asm_ff;
      word_left_in    = word_left_ff;
      posts_left_in   = posts_left_ff;
      entries_left_in = entries_left_ff;
      doc_in          = doc_ff;
      early_in        = early_ff;
      vint_in         = vint_ff;
      shift_in        = shift_ff;
      prev_pos_in     = prev_pos_ff;
      produce         = 1'b0;
      result          = '0;

      unique case (phase_ff)
         PH_WORD: begin
            produce          = 1'b1;
            result.kind      = KIND_WORD_BYTE;
            result.word_byte = req_in_byte;
            word_left_in     = word_left_dec;
            if (word_left_dec == 16'd0) begin
               phase_in = PH_NPOSTS;
               asm_in   = '0;
               idx_in   = '0;
            end
         end

         PH_NPOSTS: begin
            if (idx_ff >= LAST_IDX_Q64) begin
               idx_in        = '0;
               asm_in        = '0;
               posts_left_in = asm_full;
               if (asm_full == 64'd0) begin
                  phase_in            = PH_WLEN;
                  produce             = 1'b1;
                  result.kind         = KIND_LIST_END;
                  result.last_in_list = 1'b1;
               end else begin
                  phase_in = PH_DOC;
               end
            end else begin
               idx_in = idx_ff + 3'd1;
               asm_in = asm_full;
            end
         end

         PH_DOC: begin
            if (idx_ff >= LAST_IDX_DOC) begin
               idx_in   = '0;
               asm_in   = '0;
               doc_in   = asm_full[31:0];
               phase_in = PH_EARLY;
            end else begin
               idx_in = idx_ff + 3'd1;
               asm_in = asm_full;
            end
         end

         PH_EARLY: begin
            if (idx_ff >= LAST_IDX_Q64) begin
               idx_in   = '0;
               asm_in   = '0;
               early_in = asm_full;
               phase_in = PH_NENT;
            end else begin
               idx_in = idx_ff + 3'd1;
               asm_in = asm_full;
            end
         end

         PH_NENT: begin
            if (idx_ff >= LAST_IDX_Q64) begin
               idx_in                = '0;
               asm_in                = '0;
               entries_left_in       = asm_full;
               posts_left_in         = posts_left_dec;
               produce               = 1'b1;
               result.kind           = KIND_POST_HDR;
               result.doc_id         = doc_ff;
               result.earliest_start = early_ff;
               if (asm_full == 64'd0) begin
                  // post without entries closes here
                  result.last_in_post = 1'b1;
                  result.last_in_list = (posts_left_dec == 64'd0);
                  phase_in = (posts_left_dec == 64'd0) ? PH_WLEN : PH_DOC;
               end else begin
                  vint_in  = '0;
                  shift_in = '0;
                  phase_in = PH_VARINT;
               end
            end else begin
               idx_in = idx_ff + 3'd1;
               asm_in = asm_full;
            end
         end

         PH_VARINT: begin
            // data bits past bit 31 are dropped
            if (shift_ff < SHIFT_LIMIT) begin
               vint_in = vint_ff | ({24'd0, req_in_byte & VB_DATA_MASK} << shift_ff[4:0]);
            end
            if ((req_in_byte & VB_END_BIT) != 8'd0) begin
               phase_in = PH_LOC;
            end else begin
               shift_in = (shift_add > SHIFT_CAP) ? SHIFT_CAP : shift_add;
            end
         end

         PH_LOC: begin
            prev_pos_in           = pos_sum;
            entries_left_in       = entries_left_dec;
            produce               = 1'b1;
            result.kind           = KIND_ENTRY;
            result.doc_id         = doc_ff;
            result.earliest_start = early_ff;
            result.position       = pos_sum;
            result.location       = req_in_byte;
            if (entries_left_dec == 64'd0) begin
               result.last_in_post = 1'b1;
               result.last_in_list = (posts_left_ff == 64'd0);
               phase_in = (posts_left_ff == 64'd0) ? PH_WLEN : PH_DOC;
            end else begin
               vint_in  = '0;
               shift_in = '0;
               phase_in = PH_VARINT;
            end
         end

         default: begin
            // expecting the word length
            if (idx_ff >= LAST_IDX_WLEN) begin
               idx_in       = '0;
               asm_in       = '0;
               word_left_in = asm_full[15:0];
               prev_pos_in  = '0;
               phase_in     = (asm_full[15:0] == 16'd0) ? PH_NPOSTS : PH_WORD;
            end else begin
               idx_in = idx_ff + 3'd1;
               asm_in = (idx_ff == 3'd0) ? ({56'd0, req_in_byte}) : asm_full;
            end
         end
      endcase
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_WLEN;
         idx_ff          <= '0;
         asm_ff          <= '0;
         word_left_ff    <= '0;
         posts_left_ff   <= '0;
         entries_left_ff <= '0;
         doc_ff          <= '0;
         early_ff        <= '0;
         vint_ff         <= '0;
         shift_ff        <= '0;
         prev_pos_ff     <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         idx_ff          <= idx_in;
         asm_ff          <= asm_in;
         word_left_ff    <= word_left_in;
         posts_left_ff   <= posts_left_in;
         entries_left_ff <= entries_left_in;
         doc_ff          <= doc_in;
         early_ff        <= early_in;
         vint_ff         <= vint_in;
         shift_ff        <= shift_in;
         prev_pos_ff     <= prev_pos_in;
      end
   end

   // output register with one-entry skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept && produce) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_data_ff  <= result;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign req_stall          = skid_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_data_ff.kind;
   assign rsp_word_byte      = rsp_data_ff.word_byte;
   assign rsp_doc_id         = rsp_data_ff.doc_id;
   assign rsp_earliest_start = rsp_data_ff.earliest_start;
   assign rsp_position       = rsp_data_ff.position;
   assign rsp_location       = rsp_data_ff.location;
   assign rsp_last_in_post   = rsp_data_ff.last_in_post;
   assign rsp_last_in_list   = rsp_data_ff.last_in_list;

   // checks
   `ASSERT_NEVER(a_skid_without_out, clock, reset, skid_valid_ff && !rsp_valid_ff, "skid full while output empty")
   `ASSERT_AT(a_list_close, clock, reset, (rsp_valid_ff && rsp_data_ff.last_in_list) |-> (rsp_data_ff.last_in_post || rsp_data_ff.kind == KIND_LIST_END), "list closed without closing a post")
   `ASSERT_AT(a_shift_steps, clock, reset, shift_ff == 6'd0 || shift_ff == 6'd7 || shift_ff == 6'd14 || shift_ff == 6'd21 || shift_ff == 6'd28 || shift_ff == 6'd35, "varint shift off its step grid")
   `ASSERT_AT(a_loc_after_varint, clock, reset, (phase_ff == PH_LOC && $past(phase_ff) != PH_LOC) |-> ($past(phase_ff) == PH_VARINT), "location phase entered not from varint")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the posting list parser against a cycle-free decoder of the byte
// stream: serialized lists with random content go in, and every word byte,
// post header, entry and list end that comes out is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
   import plvp_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int END_CYCLES  = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_word_byte;
   logic [31:0] rsp_doc_id;
   logic [63:0] rsp_earliest_start;
   logic [31:0] rsp_position;
   logic [7:0]  rsp_location;
   logic        rsp_last_in_post;
   logic        rsp_last_in_list;

   // stream bytes waiting to be sent and results still owed by the block
   bit [7:0]    stream_bytes[$];
   result_type  owed_results[$];
   int          error_count = 0;
   int          quiet_cycles = 0;
   int          list_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // decoder state
   bit [2:0]  parse_phase  = PH_WLEN;
   bit [2:0]  byte_idx     = '0;
   bit [63:0] field_acc    = '0;
   bit [15:0] word_left    = '0;
   bit [63:0] posts_left   = '0;
   bit [63:0] entries_left = '0;
   bit [31:0] cur_doc      = '0;
   bit [63:0] cur_earliest = '0;
   bit [31:0] delta_acc    = '0;
   bit [5:0]  delta_shift  = '0;
   bit [31:0] last_position = '0;

   posting_list_delta_varbyte_parser_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_word_byte      (rsp_word_byte),
      .rsp_doc_id         (rsp_doc_id),
      .rsp_earliest_start (rsp_earliest_start),
      .rsp_position       (rsp_position),
      .rsp_location       (rsp_location),
      .rsp_last_in_post   (rsp_last_in_post),
      .rsp_last_in_list   (rsp_last_in_list)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // little-endian field assembly, true once the last byte is in
   function automatic bit add_field_byte(input bit [7:0] b, input bit [2:0] last_idx);
      field_acc |= 64'(b) << (8 * byte_idx);
      if (byte_idx >= last_idx) begin
         byte_idx = '0;
         return 1'b1;
      end
      byte_idx = byte_idx + 3'd1;
      return 1'b0;
   endfunction

   // decode one stream byte; returns 1 when it yields a result
   function automatic bit decode_stream_byte(input bit [7:0] b, output result_type r);
      bit       has_result;
      bit [6:0] next_shift;
      has_result = 1'b0;
      r = '0;
      case (parse_phase)
         PH_WORD: begin
            r.kind = KIND_WORD_BYTE;
            r.word_byte = b;
            has_result = 1'b1;
            word_left = word_left - 16'd1;
            if (word_left == 0) begin
               parse_phase = PH_NPOSTS;
               field_acc = '0;
               byte_idx = '0;
            end
         end
         PH_NPOSTS: begin
            if (add_field_byte(b, LAST_IDX_Q64)) begin
               posts_left = field_acc;
               field_acc = '0;
               if (posts_left == 0) begin
                  // empty list closes at once
                  parse_phase = PH_WLEN;
                  r.kind = KIND_LIST_END;
                  r.last_in_list = 1'b1;
                  has_result = 1'b1;
               end else begin
                  parse_phase = PH_DOC;
               end
            end
         end
         PH_DOC: begin
            if (add_field_byte(b, LAST_IDX_DOC)) begin
               cur_doc = field_acc[31:0];
               field_acc = '0;
               parse_phase = PH_EARLY;
            end
         end
         PH_EARLY: begin
            if (add_field_byte(b, LAST_IDX_Q64)) begin
               cur_earliest = field_acc;
               field_acc = '0;
               parse_phase = PH_NENT;
            end
         end
         PH_NENT: begin
            if (add_field_byte(b, LAST_IDX_Q64)) begin
               entries_left = field_acc;
               field_acc = '0;
               posts_left = posts_left - 64'd1;
               r.kind = KIND_POST_HDR;
               r.doc_id = cur_doc;
               r.earliest_start = cur_earliest;
               has_result = 1'b1;
               // a post with no entries is closed by its header
               if (entries_left == 0) begin
                  r.last_in_post = 1'b1;
                  r.last_in_list = (posts_left == 0);
                  parse_phase = (posts_left == 0) ? PH_WLEN : PH_DOC;
               end else begin
                  delta_acc = '0;
                  delta_shift = '0;
                  parse_phase = PH_VARINT;
               end
            end
         end
         PH_VARINT: begin
            // data bits beyond bit 31 fall off, the shift stops at its cap
            if (delta_shift < SHIFT_LIMIT)
               delta_acc |= 32'(b & VB_DATA_MASK) << delta_shift;
            if ((b & VB_END_BIT) != 0) begin
               parse_phase = PH_LOC;
            end else begin
               next_shift = 7'(delta_shift) + 7'(SHIFT_STEP);
               delta_shift = (next_shift > 7'(SHIFT_CAP)) ? SHIFT_CAP : next_shift[5:0];
            end
         end
         PH_LOC: begin
            last_position = last_position + delta_acc;
            entries_left = entries_left - 64'd1;
            r.kind = KIND_ENTRY;
            r.doc_id = cur_doc;
            r.earliest_start = cur_earliest;
            r.position = last_position;
            r.location = b;
            has_result = 1'b1;
            if (entries_left == 0) begin
               r.last_in_post = 1'b1;
               r.last_in_list = (posts_left == 0);
               parse_phase = (posts_left == 0) ? PH_WLEN : PH_DOC;
            end else begin
               delta_acc = '0;
               delta_shift = '0;
               parse_phase = PH_VARINT;
            end
         end
         default: begin
            // word length; positions restart with every list
            if (byte_idx == 0)
               field_acc = '0;
            if (add_field_byte(b, LAST_IDX_WLEN)) begin
               word_left = field_acc[15:0];
               field_acc = '0;
               last_position = '0;
               parse_phase = (word_left == 0) ? PH_NPOSTS : PH_WORD;
            end
         end
      endcase
      return has_result;
   endfunction

   function automatic void check_field(input string name, input bit [63:0] want,
                                       input bit [63:0] got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // stream building
   task automatic append_byte(input bit [7:0] b);
      stream_bytes = {stream_bytes, b};
   endtask

   task automatic put_le(input bit [63:0] value, input int nbytes);
      int k;
      for (k = 0; k < nbytes; k++)
         append_byte(value[8*k +: 8]);
   endtask

   // varint of random length and content, long ones overrun 32 bits
   task automatic put_varint();
      int       n;
      int       k;
      bit [7:0] b;
      n = ($urandom_range(9) < 6) ? $urandom_range(1, 2) : $urandom_range(3, 9);
      for (k = 0; k < n; k++) begin
         b = 8'($urandom_range(0, 127));
         if (k == n - 1)
            b = b | VB_END_BIT;
         append_byte(b);
      end
   endtask

   function automatic bit [63:0] pick_wide();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic int pick_word_len();
      if (list_count == 3 || list_count == 20)
         return 256 + $urandom_range(0, 40);
      if ($urandom_range(99) < 20)
         return 0;
      return $urandom_range(1, 6);
   endfunction

   task automatic add_random_list(input int wlen);
      int nposts;
      int nent;
      list_count++;
      put_le(64'(wlen), 2);
      repeat (wlen) append_byte(8'($urandom));
      nposts = ($urandom_range(99) < 12) ? 0 : $urandom_range(1, 4);
      put_le(64'(nposts), 8);
      repeat (nposts) begin
         put_le(pick_wide(), 4);
         put_le(pick_wide(), 8);
         nent = ($urandom_range(99) < 20) ? 0 : $urandom_range(1, 6);
         put_le(64'(nent), 8);
         repeat (nent) begin
            put_varint();
            append_byte(8'($urandom));
         end
      end
   endtask

   // hold off until the block has delivered everything it owes
   task automatic wait_drained();
      while (stream_bytes.size() != 0 || req_valid || owed_results.size() != 0)
         @(posedge clock);
   endtask

   // sender: offers the next byte, predicts on each transfer
   always @(posedge clock) begin
      result_type outcome;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (decode_stream_byte(req_in_byte, outcome))
               owed_results = {owed_results, outcome};
         end
         if (!req_valid || !req_stall) begin
            if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_in_byte <= stream_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // result check against the oldest owed result
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual kind %0d", $time,
                     rsp_kind);
            error_count++;
         end else begin
            want = owed_results.pop_front();
            check_field("kind", 64'(want.kind), 64'(rsp_kind));
            check_field("word_byte", 64'(want.word_byte), 64'(rsp_word_byte));
            check_field("doc_id", 64'(want.doc_id), 64'(rsp_doc_id));
            check_field("earliest_start", want.earliest_start, rsp_earliest_start);
            check_field("position", 64'(want.position), 64'(rsp_position));
            check_field("location", 64'(want.location), 64'(rsp_location));
            check_field("last_in_post", 64'(want.last_in_post), 64'(rsp_last_in_post));
            check_field("last_in_list", 64'(want.last_in_list), 64'(rsp_last_in_list));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // slow sender against a slow receiver
      send_idle_pct = 31;
      recv_idle_pct = 69;
      // empty word into an empty list
      put_le(64'd0, 2);
      put_le(64'd0, 8);
      // two-byte word with both byte extremes, again no posts
      put_le(64'd2, 2);
      append_byte(8'h00);
      append_byte(8'hFF);
      put_le(64'd0, 8);
      while (stream_bytes.size() < 600)
         add_random_list(pick_word_len());
      wait_drained();

      // roles swapped
      send_idle_pct = 69;
      recv_idle_pct = 31;
      while (stream_bytes.size() < 600)
         add_random_list(pick_word_len());
      wait_drained();

      // full rate, then a list whose counts never run out, then raw noise
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (stream_bytes.size() < 300)
         add_random_list(pick_word_len());
      put_le(64'($urandom_range(1, 3)), 2);
      repeat (3) append_byte(8'($urandom));
      put_le({$urandom, $urandom} | 64'h8000_0000_0000_0000, 8);
      put_le(pick_wide(), 4);
      put_le(pick_wide(), 8);
      put_le('1, 8);
      repeat (40) begin
         put_varint();
         append_byte(8'($urandom));
      end
      repeat (120) append_byte(8'($urandom));
      wait_drained();

      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0 && owed_results.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
